FILE: hw/rtl/pfcs_pkg.sv
`default_nettype none
package pfcs_pkg;

	localparam int PLANES = 4;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam logic [12:0] LIST_CAP = 13'd4096;

	typedef enum logic [2:0] {
		REG_PLANE_LEFT    = 3'd0,
		REG_PLANE_RIGHT   = 3'd1,
		REG_PLANE_BOTTOM  = 3'd2,
		REG_PLANE_TOP     = 3'd3,
		REG_GRID_ORIGIN   = 3'd4,
		REG_PATCH_SIZE    = 3'd5,
		REG_LOD_LIMIT     = 3'd6,
		REG_VISIBLE_LIMIT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        first_patch;
		logic [5:0]  patch_col;
		logic [5:0]  patch_row;
		logic [11:0] patch_lod;
		logic [3:0]  patch_tier;
		logic        has_height;
		logic signed [15:0] height_low;
		logic [15:0] height_span;
	} in_word_t;

	typedef struct packed {
		logic [11:0] slot;
		logic [5:0]  out_col;
		logic [5:0]  out_row;
		logic signed [23:0] corner_x;
		logic signed [23:0] corner_z;
		logic [11:0] out_lod;
		logic [3:0]  out_tier;
	} out_word_t;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [15:0] d;
	} plane_t;

	typedef struct packed {
		plane_t [PLANES-1:0] plane;
		logic [31:0] origin;
		logic [15:0] size;
		logic [11:0] lod_limit;
		logic [12:0] vis_limit;
	} cfg_t;

	// classified patch handed from front to back
	typedef struct packed {
		logic        first_patch;
		logic        drop;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [11:0] lod;
		logic [3:0]  tier;
		logic signed [23:0] x0;
		logic signed [23:0] x1;
		logic signed [23:0] z0;
		logic signed [23:0] z1;
		logic signed [17:0] ymin;
		logic signed [17:0] ymax;
	} cls_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pfcs_front.sv
`default_nettype none
module pfcs_front import pfcs_pkg::*; #(
	parameter int GRID_SIDE = 64,
	parameter int DEFAULT_FLOOR = -8000,
	parameter int DEFAULT_CEILING = 8000,
	parameter int SAFETY_MARGIN = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_word_t in_word,
	output logic          push,
	output cls_t          push_data,
	input  wire logic     full
);

	localparam logic [8:0] SIDE_W = 9'(GRID_SIDE);
	localparam logic signed [17:0] FLOOR_W = 18'(DEFAULT_FLOOR);
	localparam logic signed [17:0] CEIL_W = 18'(DEFAULT_CEILING);
	localparam logic signed [17:0] MARGIN_W = 18'(SAFETY_MARGIN);

	logic s1_valid_q;
	cls_t item_s1;
	cls_t cls;
	logic accept;
	logic [6:0] col_p1, row_p1;
	logic [22:0] mx0, mx1, mz0, mz1;
	logic signed [23:0] ox, oz;
	logic signed [17:0] lo;

	assign in_stall = s1_valid_q & full;
	assign accept = in_valid & ~in_stall;
	assign push = s1_valid_q & ~full;
	assign push_data = item_s1;

	always_comb begin
		col_p1 = {1'b0, in_word.patch_col} + 7'd1;
		row_p1 = {1'b0, in_word.patch_row} + 7'd1;
		mx0 = 23'(in_word.patch_col) * 23'(cfg.size);
		mx1 = 23'(col_p1) * 23'(cfg.size);
		mz0 = 23'(in_word.patch_row) * 23'(cfg.size);
		mz1 = 23'(row_p1) * 23'(cfg.size);
		ox = {{8{cfg.origin[31]}}, cfg.origin[31:16]};
		oz = {{8{cfg.origin[15]}}, cfg.origin[15:0]};
		lo = {{2{in_word.height_low[15]}}, in_word.height_low};

		cls.first_patch = in_word.first_patch;
		cls.drop = (9'(in_word.patch_col) >= SIDE_W) || (9'(in_word.patch_row) >= SIDE_W) ||
			(in_word.patch_lod > cfg.lod_limit);
		cls.col = in_word.patch_col;
		cls.row = in_word.patch_row;
		cls.lod = in_word.patch_lod;
		cls.tier = in_word.patch_tier;
		cls.x0 = ox + signed'({1'b0, mx0});
		cls.x1 = ox + signed'({1'b0, mx1});
		cls.z0 = oz + signed'({1'b0, mz0});
		cls.z1 = oz + signed'({1'b0, mz1});
		if (in_word.has_height) begin
			cls.ymin = lo - MARGIN_W;
			cls.ymax = lo + signed'({2'b00, in_word.height_span}) + MARGIN_W;
		end else begin
			cls.ymin = FLOOR_W;
			cls.ymax = CEIL_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/pfcs_queue.sv
`default_nettype none
module pfcs_queue import pfcs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cls_t push_data,
	output logic      full,
	input  wire logic pop,
	output cls_t      pop_data,
	output logic      empty
);

	cls_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign full = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/pfcs_back.sv
`default_nettype none
module pfcs_back import pfcs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	output logic      pop,
	input  wire cls_t pop_data,
	input  wire logic empty,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_word_t out_word
);

	logic en;
	logic b1_valid_q, b2_valid_q, out_valid_q;
	cls_t item_s1, item_s2;
	logic signed [39:0] px_s1 [PLANES];
	logic signed [33:0] py_s1 [PLANES];
	logic signed [39:0] pz_s1 [PLANES];
	logic signed [39:0] px_c [PLANES];
	logic signed [33:0] py_c [PLANES];
	logic signed [39:0] pz_c [PLANES];
	logic vis_c, vis_s2;
	logic signed [43:0] acc [PLANES];
	logic [12:0] emitted_q, count_eff, lim;
	logic emit;
	out_word_t word_q;

	// whole back end moves when the output register is free
	assign en = ~out_valid_q | ~out_stall;
	assign pop = en & ~empty;
	assign out_valid = out_valid_q;
	assign out_word = word_q;

	always_comb begin
		for (int p = 0; p < PLANES; p++) begin
			px_c[p] = 40'(cfg.plane[p].nx) *
				40'(cfg.plane[p].nx[15] ? pop_data.x0 : pop_data.x1);
			py_c[p] = 34'(cfg.plane[p].ny) *
				34'(cfg.plane[p].ny[15] ? pop_data.ymin : pop_data.ymax);
			pz_c[p] = 40'(cfg.plane[p].nz) *
				40'(cfg.plane[p].nz[15] ? pop_data.z0 : pop_data.z1);
		end
	end

	always_comb begin
		vis_c = 1'b1;
		for (int p = 0; p < PLANES; p++) begin
			acc[p] = 44'(px_s1[p]) + 44'(py_s1[p]) + 44'(pz_s1[p]) +
				(44'(cfg.plane[p].d) <<< 14);
			if (acc[p][43]) begin
				vis_c = 1'b0;
			end
		end
	end

	always_comb begin
		lim = (cfg.vis_limit > LIST_CAP) ? LIST_CAP : cfg.vis_limit;
		count_eff = item_s2.first_patch ? 13'd0 : emitted_q;
		emit = b2_valid_q & ~item_s2.drop & vis_s2 & (count_eff < lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q <= 1'b0;
			b2_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			emitted_q <= '0;
		end else if (en) begin
			b1_valid_q <= ~empty;
			b2_valid_q <= b1_valid_q;
			out_valid_q <= emit;
			if (b2_valid_q) begin
				emitted_q <= emit ? count_eff + 13'd1 : count_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= pop_data;
			px_s1 <= px_c;
			py_s1 <= py_c;
			pz_s1 <= pz_c;
			item_s2 <= item_s1;
			vis_s2 <= vis_c;
			if (emit) begin
				word_q.slot <= count_eff[11:0];
				word_q.out_col <= item_s2.col;
				word_q.out_row <= item_s2.row;
				word_q.corner_x <= item_s2.x0;
				word_q.corner_z <= item_s2.z0;
				word_q.out_lod <= item_s2.lod;
				word_q.out_tier <= item_s2.tier;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q <= LIST_CAP)
		else $error("emitted count beyond list size");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && b2_valid_q) |=> $stable(emitted_q))
		else $error("emitted count moved without a retiring patch");

	a_slot_step: assert property (@(posedge clk) disable iff (!arst_n)
		(en && emit) |=> (out_valid_q && emitted_q == 13'(word_q.slot) + 13'd1))
		else $error("slot and emitted count out of step");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/patch_frustum_cull_select.sv
`default_nettype none
// Terrain patch visibility selector.
// in_valid/in_stall/in_word carry one patch word; it is taken on a clock edge
// with in_valid high and in_stall low. out_valid/out_stall/out_word carry one
// visible-patch record, handed over on an edge with out_valid high and
// out_stall low. A patch that is out of the grid, above the LOD limit, outside
// any of the four planes, or past the visible limit gives no record.
// A patch passes the front register, queue, product stage, plane-sum stage
// and output register. One patch per cycle is sustained unless out_stall
// holds; the only serial part is the slot counter in the last stage.
// A four-entry queue separates front and back, so input keeps flowing for a
// few words while out_stall is held; in_stall rises once the queue is full.
// first_patch restarts slot numbering from 0.
// Reset clears all valid flags, the slot counter and the registers to their
// defaults. Registers sit on an APB-style port at byte address 8*index. The
// user must write them only while the block is idle; nothing enforces this.
module patch_frustum_cull_select import pfcs_pkg::*; #(
	parameter int GRID_SIDE = 64,
	parameter int DEFAULT_FLOOR = -8000,
	parameter int DEFAULT_CEILING = 8000,
	parameter int SAFETY_MARGIN = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_word_t    in_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_word_t        out_word
);

	cfg_t cfg_q;
	reg_idx_t idx;
	logic wr_en;
	logic push, full, pop, empty;
	cls_t push_data, pop_data;

	assign pready = 1'b1;
	assign idx = reg_idx_t'(paddr[5:3]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plane <= '0;
			cfg_q.origin <= '0;
			cfg_q.size <= 16'd16;
			cfg_q.lod_limit <= 12'd4095;
			cfg_q.vis_limit <= 13'd4096;
		end else if (wr_en) begin
			case (idx)
				REG_PLANE_LEFT:    cfg_q.plane[0] <= plane_t'(pwdata);
				REG_PLANE_RIGHT:   cfg_q.plane[1] <= plane_t'(pwdata);
				REG_PLANE_BOTTOM:  cfg_q.plane[2] <= plane_t'(pwdata);
				REG_PLANE_TOP:     cfg_q.plane[3] <= plane_t'(pwdata);
				REG_GRID_ORIGIN:   cfg_q.origin <= pwdata[31:0];
				REG_PATCH_SIZE:    cfg_q.size <= pwdata[15:0];
				REG_LOD_LIMIT:     cfg_q.lod_limit <= pwdata[11:0];
				REG_VISIBLE_LIMIT: cfg_q.vis_limit <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PLANE_LEFT:    prdata = 64'(cfg_q.plane[0]);
			REG_PLANE_RIGHT:   prdata = 64'(cfg_q.plane[1]);
			REG_PLANE_BOTTOM:  prdata = 64'(cfg_q.plane[2]);
			REG_PLANE_TOP:     prdata = 64'(cfg_q.plane[3]);
			REG_GRID_ORIGIN:   prdata = {32'd0, cfg_q.origin};
			REG_PATCH_SIZE:    prdata = {48'd0, cfg_q.size};
			REG_LOD_LIMIT:     prdata = {52'd0, cfg_q.lod_limit};
			REG_VISIBLE_LIMIT: prdata = {51'd0, cfg_q.vis_limit};
			default:           prdata = '0;
		endcase
	end

	pfcs_front #(
		.GRID_SIDE(GRID_SIDE),
		.DEFAULT_FLOOR(DEFAULT_FLOOR),
		.DEFAULT_CEILING(DEFAULT_CEILING),
		.SAFETY_MARGIN(SAFETY_MARGIN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	pfcs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	pfcs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import pfcs_pkg::*;

	localparam int GRID_SIDE = 64;
	localparam int DEFAULT_FLOOR = -8000;
	localparam int DEFAULT_CEILING = 8000;
	localparam int SAFETY_MARGIN = 16;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_WORDS = 325;

	typedef struct {
		bit          is_reg;
		reg_idx_t    ridx;
		logic [63:0] val;
		in_word_t    w;
		bit          typed;
		bit          hit;
		out_word_t   ex;
	} script_step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_word;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_word;

	// shadow of the register file and the slot counter
	plane_t      plane_cfg [PLANES];
	logic [31:0] origin_cfg;
	logic [15:0] size_cfg;
	logic [11:0] lod_lim_cfg;
	logic [12:0] vis_lim_cfg;
	logic [12:0] list_fill;

	out_word_t   visible_q [$];
	script_step_t directed [$];
	int          bad_records;
	bit          in_gaps, out_gaps;
	bit          cur_typed, cur_hit;
	out_word_t   cur_ex;

	patch_frustum_cull_select uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= out_gaps && ($urandom_range(99) < 15);
	end

	function automatic bit cull_select(input in_word_t w, output out_word_t r);
		longint sz, x0, z0, ylo, yhi, nx, ny, nz, dd, acc;
		logic [12:0] cap;
		r = '0;
		if (w.first_patch)
			list_fill = '0;
		cap = (vis_lim_cfg > LIST_CAP) ? LIST_CAP : vis_lim_cfg;
		if (list_fill >= cap)
			return 1'b0;
		if (w.patch_col >= GRID_SIDE || w.patch_row >= GRID_SIDE)
			return 1'b0;
		if (w.patch_lod > lod_lim_cfg)
			return 1'b0;
		sz = longint'(size_cfg);
		x0 = longint'($signed(origin_cfg[31:16])) + longint'(w.patch_col) * sz;
		z0 = longint'($signed(origin_cfg[15:0])) + longint'(w.patch_row) * sz;
		if (w.has_height) begin
			ylo = longint'($signed(w.height_low)) - SAFETY_MARGIN;
			yhi = longint'($signed(w.height_low)) + longint'(w.height_span) + SAFETY_MARGIN;
		end else begin
			ylo = DEFAULT_FLOOR;
			yhi = DEFAULT_CEILING;
		end
		for (int i = 0; i < PLANES; i++) begin
			nx = longint'($signed(plane_cfg[i].nx));
			ny = longint'($signed(plane_cfg[i].ny));
			nz = longint'($signed(plane_cfg[i].nz));
			dd = longint'($signed(plane_cfg[i].d));
			// p-vertex: the box corner furthest along the normal; zero picks upper
			acc = nx * ((nx >= 0) ? x0 + sz : x0) + ny * ((ny >= 0) ? yhi : ylo)
				+ nz * ((nz >= 0) ? z0 + sz : z0) + dd * 16384;
			if (acc < 0)
				return 1'b0;
		end
		r.slot = list_fill[11:0];
		r.out_col = w.patch_col;
		r.out_row = w.patch_row;
		r.corner_x = x0[23:0];
		r.corner_z = z0[23:0];
		r.out_lod = w.patch_lod;
		r.out_tier = w.patch_tier;
		list_fill = list_fill + 13'd1;
		return 1'b1;
	endfunction

	task automatic flag_record(input bit has_exp, input out_word_t e, input out_word_t g);
		bad_records++;
		if (bad_records <= 10) begin
			if (has_exp)
				$display("%0t mismatch: exp slot=%0d col=%0d row=%0d x=%0d z=%0d lod=%h tier=%0d",
					$time, e.slot, e.out_col, e.out_row, e.corner_x, e.corner_z,
					e.out_lod, e.out_tier);
			else
				$display("%0t record with no expectation pending", $time);
			$display("    got slot=%0d col=%0d row=%0d x=%0d z=%0d lod=%h tier=%0d",
				g.slot, g.out_col, g.out_row, g.corner_x, g.corner_z, g.out_lod, g.out_tier);
		end
	endtask

	// output checked before input so a same-edge push never meets the pop
	always @(posedge clk) begin
		out_word_t want, pred;
		bit p_hit;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (visible_q.size() == 0) begin
					flag_record(1'b0, '0, out_word);
				end else begin
					want = visible_q.pop_front();
					if (want.slot !== out_word.slot || want.out_col !== out_word.out_col ||
						want.out_row !== out_word.out_row ||
						want.corner_x !== out_word.corner_x ||
						want.corner_z !== out_word.corner_z ||
						want.out_lod !== out_word.out_lod ||
						want.out_tier !== out_word.out_tier)
						flag_record(1'b1, want, out_word);
				end
			end
			if (in_valid && !in_stall) begin
				p_hit = cull_select(in_word, pred);
				if (cur_typed) begin
					p_hit = cur_hit;
					pred = cur_ex;
				end
				if (p_hit)
					visible_q.push_back(pred);
			end
		end
	end

	task automatic set_reg(input reg_idx_t idx, input logic [63:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PLANE_LEFT, REG_PLANE_RIGHT, REG_PLANE_BOTTOM, REG_PLANE_TOP: begin
				plane_cfg[idx] = plane_t'(v);
			end
			REG_GRID_ORIGIN: origin_cfg = v[31:0];
			REG_PATCH_SIZE: size_cfg = v[15:0];
			REG_LOD_LIMIT: lod_lim_cfg = v[11:0];
			REG_VISIBLE_LIMIT: vis_lim_cfg = v[12:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_patch(input in_word_t w, input bit typed, input bit hit,
		input out_word_t ex);
		@(negedge clk);
		while (in_gaps && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		cur_typed = typed;
		cur_hit = hit;
		cur_ex = ex;
		do @(posedge clk); while (in_stall);
	endtask

	// culled words leave no trace, so give the pipe time past the last record
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (visible_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_word_t pw(input bit first, input int col, input int row,
		input int lod, input int tier, input bit hh, input int low, input int span);
		in_word_t w;
		w.first_patch = first;
		w.patch_col = col[5:0];
		w.patch_row = row[5:0];
		w.patch_lod = lod[11:0];
		w.patch_tier = tier[3:0];
		w.has_height = hh;
		w.height_low = low[15:0];
		w.height_span = span[15:0];
		return w;
	endfunction

	function automatic out_word_t ow(input int slot, input int col, input int row,
		input int x, input int z, input int lod, input int tier);
		out_word_t r;
		r.slot = slot[11:0];
		r.out_col = col[5:0];
		r.out_row = row[5:0];
		r.corner_x = x[23:0];
		r.corner_z = z[23:0];
		r.out_lod = lod[11:0];
		r.out_tier = tier[3:0];
		return r;
	endfunction

	function automatic void add_reg(input reg_idx_t idx, input logic [63:0] v);
		script_step_t s;
		s.is_reg = 1'b1;
		s.ridx = idx;
		s.val = v;
		s.w = '0;
		s.typed = 1'b0;
		s.hit = 1'b0;
		s.ex = '0;
		directed.push_back(s);
	endfunction

	function automatic void add_item(input in_word_t w, input bit typed = 1'b0,
		input bit hit = 1'b0, input out_word_t ex = '0);
		script_step_t s;
		s.is_reg = 1'b0;
		s.ridx = REG_PLANE_LEFT;
		s.val = '0;
		s.w = w;
		s.typed = typed;
		s.hit = hit;
		s.ex = ex;
		directed.push_back(s);
	endfunction

	function automatic in_word_t rand_patch();
		in_word_t w;
		w.first_patch = ($urandom_range(39) == 0);
		w.patch_col = 6'($urandom_range(63));
		w.patch_row = 6'($urandom_range(63));
		w.patch_lod = $urandom_range(1) ? 12'($urandom_range(0, lod_lim_cfg)) :
			12'($urandom_range(4095));
		w.patch_tier = 4'($urandom_range(15));
		w.has_height = 1'($urandom_range(1));
		w.height_low = 16'($urandom_range(65535));
		w.height_span = $urandom_range(1) ? 16'($urandom_range(255)) :
			16'($urandom_range(65535));
		return w;
	endfunction

	task automatic phase_setup(input int ph);
		logic [63:0] v;
		int nx, ny, nz, dd;
		quiesce();
		for (int k = 0; k < PLANES; k++) begin
			case (ph % 3)
				0: v = '0;
				1: begin
					nx = $urandom_range(32768) - 16384;
					ny = $urandom_range(4096) - 2048;
					nz = $urandom_range(32768) - 16384;
					dd = $urandom_range(32767) - 4096;
					v = {nx[15:0], ny[15:0], nz[15:0], dd[15:0]};
				end
				default: v = $urandom_range(1) ? {$urandom, $urandom} : 64'd0;
			endcase
			set_reg(reg_idx_t'(k), v);
		end
		set_reg(REG_GRID_ORIGIN, (ph % 2) ? 64'($urandom) : 64'd0);
		case ($urandom_range(4))
			0: v = 64'd65535;
			1: v = 64'd16;
			2, 3: v = 64'($urandom_range(1, 64));
			default: v = 64'($urandom_range(1, 65535));
		endcase
		set_reg(REG_PATCH_SIZE, v);
		set_reg(REG_LOD_LIMIT, $urandom_range(1) ? 64'd4095 : 64'($urandom_range(4095)));
		case ($urandom_range(3))
			0: v = 64'($urandom_range(1, 12));
			1: v = 64'd4096;
			2: v = 64'($urandom_range(4097, 8191));
			default: v = 64'($urandom_range(8191));
		endcase
		set_reg(REG_VISIBLE_LIMIT, v);
	endtask

	initial begin
		int ph;
		foreach (plane_cfg[i])
			plane_cfg[i] = '0;
		origin_cfg = '0;
		size_cfg = 16'd16;
		lod_lim_cfg = 12'd4095;
		vis_lim_cfg = 13'd4096;
		list_fill = '0;
		bad_records = 0;
		in_gaps = 1'b1;
		out_gaps = 1'b1;
		cur_typed = 1'b0;
		cur_hit = 1'b0;
		cur_ex = '0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: all planes zero, so every in-limit patch is visible
		add_item(pw(1, 0, 0, 0, 0, 0, 0, 0), 1, 1, ow(0, 0, 0, 0, 0, 0, 0));
		add_item(pw(0, 63, 63, 4095, 15, 1, -32768, 65535), 1, 1,
			ow(1, 63, 63, 1008, 1008, 4095, 15));
		add_item(pw(0, 5, 9, 'hABC, 7, 1, 32767, 0), 1, 1, ow(2, 5, 9, 80, 144, 'hABC, 7));
		add_item(pw(1, 1, 2, 1, 1, 0, 0, 0), 1, 1, ow(0, 1, 2, 16, 32, 1, 1));
		// LOD cull at the limit boundary
		add_reg(REG_LOD_LIMIT, 64'h100);
		add_item(pw(0, 3, 3, 'h101, 2, 0, 0, 0), 1, 0);
		add_item(pw(0, 3, 3, 'h100, 2, 0, 0, 0), 1, 1, ow(1, 3, 3, 48, 48, 'h100, 2));
		add_reg(REG_LOD_LIMIT, 64'd0);
		add_item(pw(0, 0, 1, 0, 3, 1, 0, 0), 1, 1, ow(2, 0, 1, 0, 16, 0, 3));
		add_item(pw(0, 0, 1, 1, 3, 0, 0, 0), 1, 0);
		// list full, then a new pass
		add_reg(REG_LOD_LIMIT, 64'd4095);
		add_reg(REG_VISIBLE_LIMIT, 64'd2);
		add_item(pw(1, 2, 0, 0, 4, 0, 0, 0), 1, 1, ow(0, 2, 0, 32, 0, 0, 4));
		add_item(pw(0, 2, 1, 0, 4, 0, 0, 0), 1, 1, ow(1, 2, 1, 32, 16, 0, 4));
		add_item(pw(0, 2, 2, 0, 4, 0, 0, 0), 1, 0);
		add_item(pw(1, 7, 7, 0, 5, 0, 0, 0), 1, 1, ow(0, 7, 7, 112, 112, 0, 5));
		add_reg(REG_VISIBLE_LIMIT, 64'd0);
		add_item(pw(1, 7, 7, 0, 5, 0, 0, 0), 1, 0);
		// limit above the list size clamps to 4096
		add_reg(REG_VISIBLE_LIMIT, 64'd8191);
		add_item(pw(0, 1, 1, 0, 6, 0, 0, 0), 1, 1, ow(0, 1, 1, 16, 16, 0, 6));
		// degenerate box at the origin extremes
		add_reg(REG_PATCH_SIZE, 64'd0);
		add_reg(REG_GRID_ORIGIN, 64'h8000_7FFF);
		add_item(pw(0, 63, 63, 0, 6, 0, 0, 0), 1, 1, ow(1, 63, 63, -32768, 32767, 0, 6));
		add_reg(REG_PATCH_SIZE, 64'hFFFF);
		add_reg(REG_GRID_ORIGIN, 64'h7FFF_8000);
		add_item(pw(0, 63, 63, 'h800, 8, 1, -5, 'hFFFF));
		// planes added one by one; left, right, bottom each have one nonzero normal
		add_reg(REG_PATCH_SIZE, 64'd16);
		add_reg(REG_GRID_ORIGIN, 64'd0);
		add_reg(REG_PLANE_LEFT, 64'h4000_0000_0000_FF9C);
		add_item(pw(0, 5, 0, 0, 9, 0, 0, 0));
		add_item(pw(0, 6, 0, 0, 9, 0, 0, 0));
		add_reg(REG_PLANE_RIGHT, 64'h0000_4000_0000_0000);
		add_item(pw(0, 10, 0, 0, 9, 1, -100, 50));
		add_item(pw(0, 10, 0, 0, 9, 1, -100, 84));
		add_item(pw(0, 10, 0, 0, 9, 0, -100, 50));
		add_reg(REG_PLANE_BOTTOM, 64'h0000_0000_C000_0064);
		add_item(pw(0, 10, 6, 0, 9, 0, 0, 0));
		add_item(pw(0, 10, 7, 0, 9, 0, 0, 0));
		add_reg(REG_PLANE_TOP, 64'h8000_8000_8000_8000);
		add_item(pw(0, 10, 3, 0, 1, 0, 0, 0));
		add_reg(REG_PLANE_TOP, 64'h7FFF_7FFF_7FFF_7FFF);
		add_item(pw(0, 10, 3, 0, 1, 1, 0, 0));

		foreach (directed[i]) begin
			if (directed[i].is_reg) begin
				quiesce();
				set_reg(directed[i].ridx, directed[i].val);
			end else begin
				send_patch(directed[i].w, directed[i].typed, directed[i].hit, directed[i].ex);
			end
		end

		ph = 0;
		while (ph < 6) begin
			phase_setup(ph);
			in_gaps = (ph != 2);
			out_gaps = (ph != 2);
			repeat (PHASE_WORDS)
				send_patch(rand_patch(), 1'b0, 1'b0, '0);
			ph++;
		end

		quiesce();
		if (bad_records == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: patch_frustum_cull_select.f
hw/rtl/pfcs_pkg.sv
hw/rtl/pfcs_front.sv
hw/rtl/pfcs_queue.sv
hw/rtl/pfcs_back.sv
hw/rtl/patch_frustum_cull_select.sv
verif/testbench.sv
